// File: hw/rtl/i2rd_pkg.sv
// i2rd_pkg: widths, state type, controller/datapath command and status words,
// shift and digit alphabet functions for the integer to radix digits block
// no dependencies
package i2rd_pkg;

   localparam int VALUE_W         = 31;
   localparam int RADIX_W         = 7;
   localparam int CHAR_W          = 7;
   localparam int DIGIT_W         = 6;
   localparam int MAX_DIGITS      = 31;
   localparam int IDX_W           = $clog2(MAX_DIGITS);
   localparam int WORK_W          = 32;
   localparam int STEPS_PER_CYCLE = 8;
   localparam int CHUNKS          = WORK_W / STEPS_PER_CYCLE;
   localparam int CHUNK_W         = $clog2(CHUNKS);
   localparam int DIV_W           = 4;
   localparam int REM_W           = DIV_W + 1;
   localparam int SHIFT_W         = 3;

   localparam logic [RADIX_W-1:0] RESET_RADIX = 7'd10;

   // ascii anchors of the digit alphabet
   localparam logic [CHAR_W-1:0] ASCII_ZERO  = 7'h30;
   localparam logic [CHAR_W-1:0] ASCII_UPPER = 7'h41;
   localparam logic [CHAR_W-1:0] ASCII_LOWER = 7'h61;
   localparam logic [CHAR_W-1:0] ASCII_PLUS  = 7'h2B;
   localparam logic [CHAR_W-1:0] ASCII_SLASH = 7'h2F;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONV,
      ST_PREP,
      ST_EMIT,
      ST_BAD,
      ST_EMPTY
   } state_type;

   typedef struct packed {
      logic load;
      logic conv_step;
      logic prep_read;
      logic emit_step;
      logic show_digit;
      logic show_bad;
      logic show_empty;
   } dp_cmd_type;

   typedef struct packed {
      logic radix_bad;
      logic value_zero;
      logic digit_done;
      logic last_ptr;
   } dp_status_type;

   function automatic logic [SHIFT_W-1:0] shift_amount(input logic [RADIX_W-1:0] radix);
      logic [SHIFT_W-1:0] sh;
      case (radix)
         7'd2:    sh = 3'd1;
         7'd4:    sh = 3'd2;
         7'd8:    sh = 3'd3;
         7'd16:   sh = 3'd4;
         7'd64:   sh = 3'd6;
         default: sh = 3'd0;
      endcase
      return sh;
   endfunction

   function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
      logic [CHAR_W-1:0] dx;
      logic [CHAR_W-1:0] ch;
      dx = {{(CHAR_W-DIGIT_W){1'b0}}, d};
      case (d) inside
         [6'd0:6'd9]:   ch = ASCII_ZERO + dx;
         [6'd10:6'd35]: ch = ASCII_UPPER + dx - 7'd10;
         [6'd36:6'd61]: ch = ASCII_LOWER + dx - 7'd36;
         6'd62:         ch = ASCII_PLUS;
         6'd63:         ch = ASCII_SLASH;
         default:       ch = '0;
      endcase
      return ch;
   endfunction

endpackage

// File: hw/rtl/i2rd_datapath.sv
// i2rd_datapath: radix register, digit extraction (mask/shift or 8 bit per
// cycle long division), digit store memory and readback
// depends on i2rd_pkg
module i2rd_datapath
   import i2rd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [RADIX_W-1:0]   csr_wr_data,
   input  logic [VALUE_W-1:0]   req_value,
   input  dp_cmd_type           cmd,
   output dp_status_type        status,
   output logic [CHAR_W-1:0]    rsp_digit_char,
   output logic                 rsp_last_digit,
   output logic                 rsp_bad_radix,
   output logic                 rsp_no_digits
);

   logic [RADIX_W-1:0] radix_ff, radix_in;
   logic [WORK_W-1:0]  work_ff, work_in;
   logic [DIV_W-1:0]   rem_ff, rem_in;
   logic [CHUNK_W-1:0] chunk_ff, chunk_in;
   logic [IDX_W-1:0]   count_ff, count_in;
   logic [IDX_W-1:0]   emit_ptr_ff, emit_ptr_in;
   logic [DIGIT_W-1:0] rd_data_ff;

   logic [DIGIT_W-1:0] digit_mem [MAX_DIGITS];

   logic [SHIFT_W-1:0] sh;
   logic               use_shift;
   logic [DIGIT_W-1:0] mask;
   logic [DIGIT_W-1:0] shift_digit;
   logic [WORK_W-1:0]  shift_work;
   logic [REM_W-1:0]   divisor;
   logic [REM_W-1:0]   r;
   logic [WORK_W-1:0]  w;
   logic [WORK_W-1:0]  div_work;
   logic [DIV_W-1:0]   div_rem;
   logic               last_chunk;
   logic [DIGIT_W-1:0] step_digit;
   logic               step_write;
   logic [WORK_W-1:0]  next_work;
   logic               count_limit;
   logic [IDX_W-1:0]   rd_addr;
   logic               rd_en;

   // radix decode
   assign sh        = shift_amount(radix_ff);
   assign use_shift = (sh != '0);
   assign status.radix_bad = !use_shift && !((radix_ff > 7'd2) && (radix_ff < 7'd16));
   assign status.value_zero = (req_value == '0);

   // power of two bases
   assign mask        = radix_ff[DIGIT_W-1:0] - 6'd1;
   assign shift_digit = work_ff[DIGIT_W-1:0] & mask;
   assign shift_work  = work_ff >> sh;

   // long division, STEPS_PER_CYCLE quotient bits per cycle
   assign divisor = {1'b0, radix_ff[DIV_W-1:0]};
   always_comb begin
      r = {1'b0, rem_ff};
      w = work_ff;
      for (int i = 0; i < STEPS_PER_CYCLE; i++) begin
         r = {r[DIV_W-1:0], w[WORK_W-1]};
         w = {w[WORK_W-2:0], 1'b0};
         if (r >= divisor) begin
            r    = r - divisor;
            w[0] = 1'b1;
         end
      end
      div_work = w;
      div_rem  = r[DIV_W-1:0];
   end

   assign last_chunk  = (chunk_ff == CHUNK_W'(CHUNKS - 1));
   assign step_digit  = use_shift ? shift_digit : {{(DIGIT_W-DIV_W){1'b0}}, div_rem};
   assign step_write  = cmd.conv_step && (use_shift || last_chunk);
   assign next_work   = use_shift ? shift_work : div_work;
   assign count_limit = (count_ff == IDX_W'(MAX_DIGITS - 1));
   assign status.digit_done = step_write && ((next_work == '0) || count_limit);
   assign status.last_ptr   = (emit_ptr_ff == '0);

   always_comb begin
      radix_in    = radix_ff;
      work_in     = work_ff;
      rem_in      = rem_ff;
      chunk_in    = chunk_ff;
      count_in    = count_ff;
      emit_ptr_in = emit_ptr_ff;
      if (csr_wr_en) begin
         radix_in = csr_wr_data;
      end
      if (cmd.load) begin
         work_in  = WORK_W'(req_value);
         rem_in   = '0;
         chunk_in = '0;
         count_in = '0;
      end else if (cmd.conv_step) begin
         work_in = next_work;
         if (!use_shift) begin
            rem_in   = last_chunk ? '0 : div_rem;
            chunk_in = last_chunk ? '0 : chunk_ff + 1'b1;
         end
         if (step_write) begin
            count_in = count_ff + 1'b1;
         end
      end
      if (cmd.prep_read) begin
         emit_ptr_in = count_ff - 1'b1;
      end else if (cmd.emit_step) begin
         emit_ptr_in = emit_ptr_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff    <= RESET_RADIX;
         chunk_ff    <= '0;
         count_ff    <= '0;
         emit_ptr_ff <= '0;
      end else begin
         radix_ff    <= radix_in;
         chunk_ff    <= chunk_in;
         count_ff    <= count_in;
         emit_ptr_ff <= emit_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      rem_ff  <= rem_in;
   end

   // digit store, least significant digit first
   assign rd_addr = cmd.prep_read ? (count_ff - 1'b1) : (emit_ptr_ff - 1'b1);
   assign rd_en   = cmd.prep_read || (cmd.emit_step && !status.last_ptr);

   always_ff @(posedge clock) begin
      if (step_write) begin
         digit_mem[count_ff] <= step_digit;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= digit_mem[rd_addr];
      end
   end

   assign rsp_digit_char = cmd.show_digit ? digit_to_ascii(rd_data_ff) : '0;
   assign rsp_last_digit = cmd.show_bad || cmd.show_empty ||
                           (cmd.show_digit && status.last_ptr);
   assign rsp_bad_radix  = cmd.show_bad;
   assign rsp_no_digits  = cmd.show_empty;

endmodule

// File: hw/rtl/i2rd_ctrl.sv
// i2rd_ctrl: sequencing state machine for conversion and digit readback
// depends on i2rd_pkg
module i2rd_ctrl
   import i2rd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  dp_status_type status,
   output dp_cmd_type    cmd,
   output logic          busy,
   output logic          rsp_strobe
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (status.radix_bad) begin
                  state_in = ST_BAD;
               end else begin
                  cmd.load = 1'b1;
                  state_in = status.value_zero ? ST_EMPTY : ST_CONV;
               end
            end
         end
         ST_CONV: begin
            cmd.conv_step = 1'b1;
            if (status.digit_done) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.prep_read = 1'b1;
            state_in      = ST_EMIT;
         end
         ST_EMIT: begin
            cmd.emit_step  = 1'b1;
            cmd.show_digit = 1'b1;
            if (status.last_ptr) begin
               state_in = ST_IDLE;
            end
         end
         ST_BAD: begin
            cmd.show_bad = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_EMPTY: begin
            cmd.show_empty = 1'b1;
            state_in       = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = cmd.show_digit || cmd.show_bad || cmd.show_empty;

   a_one_kind: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.show_digit, cmd.show_bad, cmd.show_empty}))
      else $error("more than one result kind shown");

   a_start_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && start) |=> (state_ff != ST_IDLE))
      else $error("accepted word did not start work");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && status.last_ptr) |=> (state_ff == ST_IDLE))
      else $error("readback did not stop after last digit");

   a_prep_to_emit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PREP) |=> (state_ff == ST_EMIT && rsp_strobe))
      else $error("digit readback did not follow prefetch");

endmodule

// File: hw/rtl/integer_to_radix_digits.sv
// integer_to_radix_digits: one word in, its digits out as ascii, msd first
// per word: a conversion pass (mask/shift for bases 2, 4, 8, 16, 64, or
// 8 bit per cycle long division for bases 3 to 15), a prefetch, then the
// digit readback; bad radix or zero value give one result in the next cycle
// first digit appears after the conversion pass; results cannot be stalled
// synchronous active high reset: idle, radix 10, digit count 0
module integer_to_radix_digits
   import i2rd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   // configuration: radix register
   input  logic                csr_wr_en,
   input  logic [RADIX_W-1:0]  csr_wr_data,
   // request word
   input  logic                start,
   output logic                busy,
   input  logic [VALUE_W-1:0]  req_value,
   // result words, one cycle each
   output logic                rsp_strobe,
   output logic [CHAR_W-1:0]   rsp_digit_char,
   output logic                rsp_last_digit,
   output logic                rsp_bad_radix,
   output logic                rsp_no_digits
);

   // command and status words between sequencer and datapath
   dp_cmd_type    cmd;
   dp_status_type status;

   // sequencer: idle, conversion pass, prefetch, digit readback,
   // or a single flag result for bad radix / zero value
   i2rd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .status     (status),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   // datapath: radix register, digit extraction, digit store, ascii map
   i2rd_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_value      (req_value),
      .cmd            (cmd),
      .status         (status),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last_digit (rsp_last_digit),
      .rsp_bad_radix  (rsp_bad_radix),
      .rsp_no_digits  (rsp_no_digits)
   );

endmodule
